// ===== rtl/ea_avg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Energy accumulator average power - shared types and constants
// Field widths, status and register codes, controller states, the request
// carried to the serial divider and the power-of-ten table.
// ============================================================================
package ea_avg_pkg;

    localparam int LOW_W     = 15;
    localparam int ROLL_W    = 8;
    localparam int ENERGY_W  = LOW_W + ROLL_W;
    localparam int SAMPLE_W  = 24;
    localparam int RAW_W     = 16;
    localparam int AVG_W     = 15;
    localparam int SLOPE_W   = 15;
    localparam int OFFSET_W  = 16;
    localparam int EXP_W     = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int POW_W     = 27;
    localparam int MULA_W    = 17;
    localparam int MULP_W    = MULA_W + POW_W + 1;
    localparam int NUM_W     = 44;
    localparam int DEN_W     = 42;
    localparam int DIVQ_W    = ENERGY_W;
    localparam int STEP_W    = 5;

    localparam logic [STEP_W-1:0] STEPS_RAW = STEP_W'(DIVQ_W);
    localparam logic [STEP_W-1:0] STEPS_AVG = STEP_W'(AVG_W);

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_NO_DELTA = 2'd1;
    localparam status_t STATUS_RANGE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SLOPE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_MUL1,
        ST_MUL2,
        ST_CHECK,
        ST_DIV2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [DEN_W-1:0]  rem_init;
        logic [DIVQ_W-1:0] dividend;
        logic [DEN_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    function automatic logic [POW_W-1:0] pow10(input logic [3:0] idx);
        logic [POW_W-1:0] val;
        case (idx)
            4'd0:    val = 27'd1;
            4'd1:    val = 27'd10;
            4'd2:    val = 27'd100;
            4'd3:    val = 27'd1000;
            4'd4:    val = 27'd10000;
            4'd5:    val = 27'd100000;
            4'd6:    val = 27'd1000000;
            4'd7:    val = 27'd10000000;
            4'd8:    val = 27'd100000000;
            default: val = 27'd1;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ea_avg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Serial restoring divider
// Shifts one dividend bit into the partial remainder per cycle and develops
// one quotient bit per cycle; the step count and initial remainder come with
// the request so the same unit serves both divisions of the block.
// ============================================================================
module ea_avg_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire ea_avg_pkg::div_req_t          req,
    output logic                               done,
    output logic [ea_avg_pkg::DIVQ_W-1:0]      quotient
);

    logic [ea_avg_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [ea_avg_pkg::DIVQ_W-1:0] dividend_reg, dividend_next;
    logic [ea_avg_pkg::DEN_W-1:0]  divisor_reg, divisor_next;
    logic [ea_avg_pkg::DIVQ_W-1:0] quot_reg, quot_next;
    logic [ea_avg_pkg::STEP_W-1:0] count_reg, count_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ea_avg_pkg::DEN_W:0]    trial;
    logic [ea_avg_pkg::DEN_W:0]    diff;

    always_comb
    begin
        trial         = {rem_reg, dividend_reg[ea_avg_pkg::DIVQ_W-1]};
        diff          = trial - {1'b0, divisor_reg};
        rem_next      = rem_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        quot_next     = quot_reg;
        count_next    = count_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        if (start)
        begin
            rem_next      = req.rem_init;
            dividend_next = req.dividend;
            divisor_next  = req.divisor;
            quot_next     = '0;
            count_next    = req.steps;
            busy_next     = 1'b1;
        end
        else if (busy_reg)
        begin
            dividend_next = {dividend_reg[ea_avg_pkg::DIVQ_W-2:0], 1'b0};
            // The remainder stays below the divisor, so it always fits DEN_W bits.
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next  = diff[ea_avg_pkg::DEN_W-1:0];
                quot_next = {quot_reg[ea_avg_pkg::DIVQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[ea_avg_pkg::DEN_W-1:0];
                quot_next = {quot_reg[ea_avg_pkg::DIVQ_W-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == ea_avg_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        quot_reg     <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

// ===== rtl/energy_accumulator_average_power_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Energy accumulator average power unit
// Turns successive energy-meter snapshots into a direct-format average
// power reading with a validity status.
// ============================================================================
// Usage: one snapshot beat (energy_low, energy_rollovers, sample_total) enters
// on the input channel when in_valid is high and in_stall is low; exactly one
// result beat (status, avg_power) leaves on the output channel for it.
// The slope, offset and exponent registers are written through cfg_we,
// cfg_index and cfg_data; the user must do so only while no snapshot is in
// flight, as the block does not enforce it. A snapshot with a usable delta
// passes through ST_DIV1, ST_MUL1, ST_MUL2, ST_CHECK and, unless the check
// ends it, ST_DIV2 to ST_DONE; the next snapshot is taken once its result is
// loaded into the output register. The one-bit-per-cycle shared divider runs
// 23 steps for the energy/sample quotient and 15 for the final scaling. A
// snapshot with no usable delta, or a zero slope, goes straight to ST_DONE.
// The unit works on one snapshot at a time; in_stall is high while it does.
// A finished result sits in the output register; while out_stall holds it,
// the unit still accepts and processes the next snapshot and waits only to
// hand over that one. Reset clears the previous counts, restores slope 1,
// offset 0 and exponent 0, and empties the output register.
// ============================================================================
module energy_accumulator_average_power_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [ea_avg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ea_avg_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [ea_avg_pkg::LOW_W-1:0]         energy_low,
    input  wire logic [ea_avg_pkg::ROLL_W-1:0]        energy_rollovers,
    input  wire logic [ea_avg_pkg::SAMPLE_W-1:0]      sample_total,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [1:0]                                status,
    output logic [ea_avg_pkg::AVG_W-1:0]              avg_power
);

    localparam int HI_W = ea_avg_pkg::NUM_W - ea_avg_pkg::AVG_W;

    ea_avg_pkg::state_t state_reg, state_next;

    logic [ea_avg_pkg::SLOPE_W-1:0]  slope_reg;
    logic [ea_avg_pkg::OFFSET_W-1:0] offset_reg;
    logic [ea_avg_pkg::EXP_W-1:0]    exp_reg;
    logic [ea_avg_pkg::ENERGY_W-1:0] prev_energy_reg;
    logic [ea_avg_pkg::SAMPLE_W-1:0] prev_samples_reg;

    logic [ea_avg_pkg::RAW_W-1:0]    raw_reg, raw_next;
    logic [ea_avg_pkg::NUM_W-1:0]    prod_reg, prod_next;
    logic [ea_avg_pkg::NUM_W-1:0]    num_reg, num_next;
    logic [ea_avg_pkg::DEN_W-1:0]    den_reg, den_next;
    ea_avg_pkg::status_t             res_status_reg, res_status_next;
    logic [ea_avg_pkg::AVG_W-1:0]    res_avg_reg, res_avg_next;

    logic                            out_valid_reg;
    ea_avg_pkg::status_t             out_status_reg;
    logic [ea_avg_pkg::AVG_W-1:0]    out_avg_reg;
    logic                            out_load;

    logic                            accept;
    logic [ea_avg_pkg::ENERGY_W-1:0] energy;
    logic [ea_avg_pkg::ENERGY_W-1:0] delta_energy;
    logic [ea_avg_pkg::SAMPLE_W-1:0] delta_samples;
    logic                            usable;
    logic                            exp_neg;
    logic [3:0]                      pow_idx;
    logic [ea_avg_pkg::POW_W-1:0]    pow;
    logic signed [ea_avg_pkg::MULA_W-1:0] mul_a;
    logic signed [ea_avg_pkg::POW_W:0]    mul_b;
    logic signed [ea_avg_pkg::MULP_W-1:0] mul_p;
    logic [ea_avg_pkg::NUM_W-1:0]    num_mag;
    logic [HI_W-1:0]                 num_hi;

    logic                            div_start;
    ea_avg_pkg::div_req_t            div_req;
    logic                            div_done;
    logic [ea_avg_pkg::DIVQ_W-1:0]   div_quot;

    ea_avg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign in_stall = (state_reg != ea_avg_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    assign energy        = {energy_rollovers, energy_low};
    assign delta_energy  = energy - prev_energy_reg;
    assign delta_samples = sample_total - prev_samples_reg;
    assign usable        = (sample_total > prev_samples_reg) && (energy > prev_energy_reg)
                           && (prev_samples_reg != '0) && (prev_energy_reg != '0);

    // A negative exponent scales the offset and slope up instead of the raw value.
    assign exp_neg = exp_reg[ea_avg_pkg::EXP_W-1];
    assign pow_idx = exp_neg ? (4'd0 - exp_reg) : {1'b0, exp_reg[2:0]};
    assign pow     = ea_avg_pkg::pow10(pow_idx);

    always_comb
    begin
        if (state_reg == ea_avg_pkg::ST_MUL1)
        begin
            if (exp_neg)
                mul_a = {offset_reg[ea_avg_pkg::OFFSET_W-1], offset_reg};
            else
                mul_a = {1'b0, raw_reg};
        end
        else
        begin
            mul_a = {2'b00, slope_reg};
        end
    end

    assign mul_b   = {1'b0, pow};
    assign mul_p   = mul_a * mul_b;
    assign num_mag = '0 - num_reg;
    assign num_hi  = num_reg[ea_avg_pkg::NUM_W-1:ea_avg_pkg::AVG_W];

    always_comb
    begin
        state_next      = state_reg;
        raw_next        = raw_reg;
        prod_next       = prod_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        res_status_next = res_status_reg;
        res_avg_next    = res_avg_reg;
        div_start       = 1'b0;
        div_req         = '0;
        out_load        = 1'b0;
        case (state_reg)
            ea_avg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_avg_next = '0;
                    if (!usable)
                    begin
                        res_status_next = ea_avg_pkg::STATUS_NO_DELTA;
                        state_next      = ea_avg_pkg::ST_DONE;
                    end
                    else if (slope_reg == '0)
                    begin
                        res_status_next = ea_avg_pkg::STATUS_RANGE;
                        state_next      = ea_avg_pkg::ST_DONE;
                    end
                    else
                    begin
                        div_start        = 1'b1;
                        div_req.rem_init = '0;
                        div_req.dividend = delta_energy;
                        div_req.divisor  = {{(ea_avg_pkg::DEN_W-ea_avg_pkg::SAMPLE_W){1'b0}},
                                            delta_samples};
                        div_req.steps    = ea_avg_pkg::STEPS_RAW;
                        state_next       = ea_avg_pkg::ST_DIV1;
                    end
                end
            end
            ea_avg_pkg::ST_DIV1:
            begin
                if (div_done)
                begin
                    raw_next   = div_quot[ea_avg_pkg::RAW_W-1:0];
                    state_next = ea_avg_pkg::ST_MUL1;
                end
            end
            ea_avg_pkg::ST_MUL1:
            begin
                prod_next  = mul_p[ea_avg_pkg::NUM_W-1:0];
                state_next = ea_avg_pkg::ST_MUL2;
            end
            ea_avg_pkg::ST_MUL2:
            begin
                if (exp_neg)
                begin
                    num_next = {{(ea_avg_pkg::NUM_W-ea_avg_pkg::RAW_W){1'b0}}, raw_reg}
                               - prod_reg;
                    den_next = mul_p[ea_avg_pkg::DEN_W-1:0];
                end
                else
                begin
                    num_next = prod_reg
                               - {{(ea_avg_pkg::NUM_W-ea_avg_pkg::OFFSET_W)
                                   {offset_reg[ea_avg_pkg::OFFSET_W-1]}}, offset_reg};
                    den_next = {{(ea_avg_pkg::DEN_W-ea_avg_pkg::SLOPE_W){1'b0}}, slope_reg};
                end
                state_next = ea_avg_pkg::ST_CHECK;
            end
            ea_avg_pkg::ST_CHECK:
            begin
                res_avg_next = '0;
                if (num_reg[ea_avg_pkg::NUM_W-1])
                begin
                    // A negative fraction above minus one truncates to a valid zero.
                    if (num_mag < {{(ea_avg_pkg::NUM_W-ea_avg_pkg::DEN_W){1'b0}}, den_reg})
                        res_status_next = ea_avg_pkg::STATUS_OK;
                    else
                        res_status_next = ea_avg_pkg::STATUS_RANGE;
                    state_next = ea_avg_pkg::ST_DONE;
                end
                else if ({{(ea_avg_pkg::DEN_W-HI_W){1'b0}}, num_hi} >= den_reg)
                begin
                    // The quotient would need more than 15 bits.
                    res_status_next = ea_avg_pkg::STATUS_RANGE;
                    state_next      = ea_avg_pkg::ST_DONE;
                end
                else
                begin
                    div_start        = 1'b1;
                    div_req.rem_init = {{(ea_avg_pkg::DEN_W-HI_W){1'b0}}, num_hi};
                    div_req.dividend = {num_reg[ea_avg_pkg::AVG_W-1:0],
                                        {(ea_avg_pkg::DIVQ_W-ea_avg_pkg::AVG_W){1'b0}}};
                    div_req.divisor  = den_reg;
                    div_req.steps    = ea_avg_pkg::STEPS_AVG;
                    state_next       = ea_avg_pkg::ST_DIV2;
                end
            end
            ea_avg_pkg::ST_DIV2:
            begin
                if (div_done)
                begin
                    res_avg_next    = div_quot[ea_avg_pkg::AVG_W-1:0];
                    res_status_next = ea_avg_pkg::STATUS_OK;
                    state_next      = ea_avg_pkg::ST_DONE;
                end
            end
            ea_avg_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ea_avg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ea_avg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ea_avg_pkg::ST_IDLE;
            slope_reg        <= ea_avg_pkg::SLOPE_W'(1);
            offset_reg       <= '0;
            exp_reg          <= '0;
            prev_energy_reg  <= '0;
            prev_samples_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ea_avg_pkg::REG_SLOPE:    slope_reg  <= cfg_data[ea_avg_pkg::SLOPE_W-1:0];
                    ea_avg_pkg::REG_OFFSET:   offset_reg <= cfg_data;
                    ea_avg_pkg::REG_EXPONENT: exp_reg    <= cfg_data[ea_avg_pkg::EXP_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                prev_energy_reg  <= energy;
                prev_samples_reg <= sample_total;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg        <= raw_next;
        prod_reg       <= prod_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        res_status_reg <= res_status_next;
        res_avg_reg    <= res_avg_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_avg_reg    <= res_avg_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign avg_power = out_avg_reg;

`ifndef SYNTHESIS
    a_err_zero_power: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ea_avg_pkg::STATUS_OK) |-> (avg_power == '0))
        else $error("average power is nonzero on an error status");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ea_avg_pkg::ST_DIV1) || (state_reg == ea_avg_pkg::ST_DIV2))
        else $error("divider finished while the controller was not waiting for it");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ea_avg_pkg::ST_IDLE))
        else $error("accepted snapshot did not start processing");
`endif

endmodule
`default_nettype wire
